>>> hdl/palette_pixel_repack_interleave_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the palette pixel repacker
// Shared property wrappers; they use clk and rst_n from the enclosing module.
// ----------------------------------------------------------------------------
`ifndef PALETTE_PIXEL_REPACK_INTERLEAVE_TOP_MACROS_SVH
`define PALETTE_PIXEL_REPACK_INTERLEAVE_TOP_MACROS_SVH

// same-cycle implication
`define PPRI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPRI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ppri_pkg.sv
// ----------------------------------------------------------------------------
// ppri_pkg
// Types, codes and helpers shared by the palette pixel repacker.
// ----------------------------------------------------------------------------
package ppri_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;  // width/height register bits
  localparam int POS_W  = 10;  // column / row counters
  localparam int ADDR_W = 19;
  localparam int HALF_W = 10;  // width/2
  localparam int BANK_W = 18;  // bank size in bytes

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(320);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(200);
  localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH & ~7);
  localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT & ~3);

  // pixel_mode codes
  localparam logic [1:0] MODE_2BPP = 2'd0;
  localparam logic [1:0] MODE_4BPP = 2'd1;
  localparam logic [1:0] MODE_8BPP = 2'd2;
  localparam logic [1:0] MODE_OFF  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [ADDR_W-1:0] out_addr;
    logic              index_high;
    logic              run_last;
    logic              frame_last;
  } res_item_t;

  // effective configuration as seen by the datapath
  typedef struct packed {
    logic [1:0]        mode;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [HALF_W-1:0] half;
    logic [BANK_W-1:0] bank;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [3:0]        held_nib;
    logic              held;
    logic              held_flag;
    logic [ADDR_W-1:0] base;
  } pos_t;

  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] w;
    w = {raw[DIM_W-1:3], 3'b000};
    if (w > WIDTH_MAX) w = WIDTH_MAX;
    if (w < DIM_W'(8)) w = DIM_W'(8);
    return w;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] h;
    h = {raw[DIM_W-1:2], 2'b00};
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    if (h < DIM_W'(4)) h = DIM_W'(4);
    return h;
  endfunction

  // (w/2) * (h/4), both already effective
  function automatic logic [BANK_W-1:0] bank_size(input logic [DIM_W-1:0] w,
                                                  input logic [DIM_W-1:0] h);
    logic [HALF_W-1:0] half;
    logic [8:0]        quarter;
    logic [18:0]       prod;
    half    = w[DIM_W-1:1];
    quarter = h[DIM_W-1:2];
    prod    = 19'(half) * 19'(quarter);
    return prod[BANK_W-1:0];
  endfunction

endpackage

>>> hdl/ppri_cfg.sv
// ----------------------------------------------------------------------------
// ppri_cfg
// Configuration registers; keeps the bank size precomputed at write time.
// ----------------------------------------------------------------------------
module ppri_cfg
  import ppri_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic [1:0]        mode_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [BANK_W-1:0] bank_r;
  logic [DIM_W-1:0]  eff_w;
  logic [DIM_W-1:0]  eff_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_2BPP;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      bank_r   <= bank_size(eff_width(WIDTH_RESET), eff_height(HEIGHT_RESET));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= cfg_data[1:0];
        REG_WIDTH: begin
          width_r <= cfg_data;
          bank_r  <= bank_size(eff_width(cfg_data), eff_h);
        end
        REG_HEIGHT: begin
          height_r <= cfg_data;
          bank_r   <= bank_size(eff_w, eff_height(cfg_data));
        end
        default: ;
      endcase
    end
  end

  assign eff_w = eff_width(width_r);
  assign eff_h = eff_height(height_r);

  assign cfg.mode   = mode_r;
  assign cfg.width  = eff_w;
  assign cfg.height = eff_h;
  assign cfg.half   = eff_w[DIM_W-1:1];
  assign cfg.bank   = bank_r;

endmodule

>>> hdl/ppri_step.sv
// ----------------------------------------------------------------------------
// ppri_step
// One packing step: up to two source pixels, at most one packed byte out,
// plus the position and row base update.
// ----------------------------------------------------------------------------
module ppri_step
  import ppri_pkg::*;
(
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      phase,   // second half of a 2bpp byte
  input  pos_t      cur,
  output pos_t      nxt,
  output logic      has_res,
  output res_item_t res
);

  always_comb begin
    pos_t              st;
    logic [3:0]        pix_a;
    logic [3:0]        pix_b;
    logic              flag_a;
    logic              two;
    logic              none;
    logic [DIM_W-1:0]  col2;
    logic [DIM_W-1:0]  row1;
    logic [POS_W-1:0]  new_row;
    logic [ADDR_W-1:0] bank_part;
    logic [17:0]       row_part;
    logic [ADDR_W-1:0] b1;
    logic [ADDR_W-1:0] b2;

    st = cur;
    if (item.frame_start && !phase && cfg.mode != MODE_OFF) st = '0;

    pix_a  = '0;
    pix_b  = '0;
    flag_a = 1'b0;
    two    = 1'b0;
    none   = 1'b0;
    unique case (cfg.mode)
      MODE_2BPP: begin
        two = 1'b1;
        if (!phase) begin
          pix_a = {1'b0, item.src_byte[7:6], 1'b0};
          pix_b = {1'b0, item.src_byte[5:4], 1'b0};
        end else begin
          pix_a = {1'b0, item.src_byte[3:2], 1'b0};
          pix_b = {1'b0, item.src_byte[1:0], 1'b0};
        end
      end
      MODE_4BPP: begin
        two   = 1'b1;
        pix_a = item.src_byte[7:4];
        pix_b = item.src_byte[3:0];
      end
      MODE_8BPP: begin
        pix_a  = (item.src_byte[3:0] <= 4'd3) ? {item.src_byte[2:0], 1'b0}
                                              : item.src_byte[3:0];
        flag_a = |item.src_byte[7:2];
      end
      default: none = 1'b1;
    endcase

    nxt     = st;
    has_res = 1'b0;
    res     = '0;

    if (!none) begin
      if (st.held) begin
        has_res        = 1'b1;
        res.out_byte   = {st.held_nib, pix_a};
        res.index_high = st.held_flag | flag_a;
        nxt.held       = two;
        nxt.held_nib   = two ? pix_b : 4'd0;
        nxt.held_flag  = 1'b0;  // second pixel only exists in flagless modes
      end else if (two) begin
        has_res        = 1'b1;
        res.out_byte   = {pix_a, pix_b};
        res.index_high = 1'b0;
      end else begin
        nxt.held      = 1'b1;
        nxt.held_nib  = pix_a;
        nxt.held_flag = flag_a;
      end
    end

    res.out_addr   = st.base + ADDR_W'(st.col[POS_W-1:1]);
    res.run_last   = (cfg.mode != MODE_2BPP) || phase;
    res.frame_last = 1'b0;

    // advance one pair; on a row change recompute the bank-interleaved base
    col2    = DIM_W'(st.col) + DIM_W'(2);
    row1    = DIM_W'(st.row) + DIM_W'(1);
    new_row = (row1 >= cfg.height) ? '0 : row1[POS_W-1:0];
    b1      = ADDR_W'(cfg.bank);
    b2      = {cfg.bank, 1'b0};
    case (new_row[1:0])
      2'd0:    bank_part = '0;
      2'd1:    bank_part = b1;
      2'd2:    bank_part = b2;
      default: bank_part = b1 + b2;
    endcase
    row_part = 18'(new_row[POS_W-1:2]) * 18'(cfg.half);

    if (has_res) begin
      if (col2 >= cfg.width) begin
        nxt.col        = '0;
        nxt.row        = new_row;
        res.frame_last = (row1 >= cfg.height);
        nxt.base       = bank_part + ADDR_W'(row_part);
      end else begin
        nxt.col = col2[POS_W-1:0];
      end
    end
  end

endmodule

>>> hdl/palette_pixel_repack_interleave_top.sv
// ----------------------------------------------------------------------------
// palette_pixel_repack_interleave_top
// Path: an accepted beat is registered in item_r, and its first packed byte in out_r.
// Throughput: one beat per cycle at 4 and 8 bpp while out_stall is low; a 2bpp beat is
// split into halves by phase_r, as the single result register takes one packed byte per cycle.
// Reset: synchronous active-low; position, held pixel and row base go to zero,
// registers to mode 0, 320 x 200. No clearing pass.
// ----------------------------------------------------------------------------
`include "palette_pixel_repack_interleave_top_macros.svh"

module palette_pixel_repack_interleave_top
  import ppri_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output res_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_vld_r;
  logic      phase_r;
  pos_t      pos_r;
  pos_t      pos_nxt;
  logic      step_res;
  res_item_t step_out;
  res_item_t out_r;
  logic      out_vld_r;
  logic      out_free;
  logic      step_go;
  logic      item_done;

  ppri_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppri_step u_step (
    .cfg     (cfg),
    .item    (item_r),
    .phase   (phase_r),
    .cur     (pos_r),
    .nxt     (pos_nxt),
    .has_res (step_res),
    .res     (step_out)
  );

  assign out_free  = !out_vld_r || !out_stall;
  assign step_go   = item_vld_r && (out_free || !step_res);
  assign item_done = step_go && (cfg.mode != MODE_2BPP || phase_r);
  assign in_stall  = item_vld_r && !item_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      phase_r    <= 1'b0;
      pos_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_vld_r <= 1'b1;
      end else if (item_done) begin
        item_vld_r <= 1'b0;
      end
      if (step_go) begin
        phase_r <= !item_done;
        pos_r   <= pos_nxt;
      end
      if (step_go && step_res) begin
        out_vld_r <= 1'b1;
      end else if (out_free) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
    if (step_go && step_res) out_r <= step_out;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `PPRI_ASSERT_IMP(a_col_even, 1'b1, !pos_r.col[0], "column position went odd")
  `PPRI_ASSERT_IMP(a_phase_mode, item_vld_r && phase_r, cfg.mode == MODE_2BPP,
                   "second half of a beat outside 2bpp mode")
  `PPRI_ASSERT_NXT(a_hold_item, item_vld_r && !item_done, item_vld_r && $stable(item_r),
                   "pending beat dropped before it was finished")
  `PPRI_ASSERT_NXT(a_frame_wrap, step_go && step_res && step_out.frame_last,
                   pos_r.col == '0 && pos_r.row == '0 && pos_r.base == '0,
                   "position did not wrap after the last byte of the image")

endmodule
